// ===== sv/lpl_pkg.sv =====
// shared types and constants of the lookahead peak limiter
package lpl_pkg;

   localparam int SAMPLE_W = 24;
   localparam int LEN_W    = 9;
   localparam int COEF_W   = 24;
   localparam int GAIN_W   = 25;
   localparam int PEAK_W   = 24;
   localparam logic [GAIN_W-1:0] UNITY_GAIN   = 25'd16777216;
   localparam logic [COEF_W-1:0] CEIL_RESET   = 24'd8388608;
   localparam logic [COEF_W-1:0] COEF_RESET   = 24'd16742299;
   localparam logic [LEN_W-1:0]  LEN_RESET    = 9'd240;
   localparam logic [LEN_W-1:0]  MIN_FRAMES   = 9'd8;

   // register indexes
   localparam logic [1:0] REG_CEILING   = 2'd0;
   localparam logic [1:0] REG_RELEASE   = 2'd1;
   localparam logic [1:0] REG_LOOKAHEAD = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
      logic                       drain;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       last;
   } rsp_word_type;

   // ring entry: samples and real flag
   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic                real_flag;
   } slot_type;

   // divider handshake
   typedef struct packed {
      logic                start;
      logic [PEAK_W-1:0]   ceil_v;
      logic [PEAK_W-1:0]   peak;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [GAIN_W-1:0]   quot;
   } div_rsp_type;

   // magnitude of a sample, fits in sample width unsigned
   function automatic logic [PEAK_W-1:0] mag(input logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] n;
      begin
         n = (~s) + SAMPLE_W'(1);
         mag = s[SAMPLE_W-1] ? n : s;
      end
   endfunction

endpackage

// ===== sv/lpl_ram.sv =====
// generic single-port write, single-port read ram with registered read
module lpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/lpl_div.sv =====
// restoring divider, one quotient bit per cycle: (ceil << 24) / peak
module lpl_div (
   input  logic                      clock,
   input  logic                      reset,
   input  lpl_pkg::div_cmd_type      cmd,
   output lpl_pkg::div_rsp_type      rsp
);
   import lpl_pkg::*;
   localparam int NUM_W = PEAK_W + 24;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [PEAK_W:0]   rem_ff, rem_in;
   logic [PEAK_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PEAK_W:0]   trial;
   logic [PEAK_W:0]   diff;

   // one shift-subtract step
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[PEAK_W-1:0], num_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      if (cmd.start) begin
         num_in  = {cmd.ceil_v, 24'd0};
         rem_in  = '0;
         den_in  = cmd.peak;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[PEAK_W]) begin
            rem_in = diff;
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // quotient is below 2^24 since peak > ceiling
   assign rsp.done = done_ff;
   assign rsp.quot = GAIN_W'(num_ff[23:0]);
endmodule

// ===== sv/lookahead_peak_limiter.sv =====
// lookahead peak limiter: one ring memory scanned per frame, serial divider
// the time from accept to result grows with the window length and with the
// divide, which is skipped when the peak stays within the ceiling
// one word at a time: the next word is taken only after the ring scan, the
// divide wait and the output step of the last one, or its write while filling
// reset: a clearing pass over the whole ring, no word accepted meanwhile;
// registers return to ceiling 1.0, release 16742299, window 240
module lookahead_peak_limiter #(
   parameter int LOOKAHEAD_MAX = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lpl_pkg::req_word_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lpl_pkg::rsp_word_type  rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [23:0]            csr_wdata
);
   import lpl_pkg::*;
   localparam int AW    = $clog2(LOOKAHEAD_MAX);
   localparam int CNT_W = $clog2(LOOKAHEAD_MAX + 1);
   localparam int SLOT_W = $bits(slot_type);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_WRITE = 8'b0000_0100,
      ST_SCAN  = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_REL   = 8'b0010_0000,
      ST_MUL   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [COEF_W-1:0]  ceil_ff, coef_ff;
   logic [LEN_W-1:0]   look_ff;
   logic [AW-1:0]      wpos_ff, wpos_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [AW-1:0]      oldest_ff, oldest_in;
   logic [PEAK_W-1:0]  peak_ff, peak_in;
   logic               later_ff, later_in;
   logic               first_ff, first_in;
   logic               rdv_ff, rdv_in;
   logic               rdk0_ff, rdk0_in;
   slot_type           old_ff, old_in;
   logic [GAIN_W-1:0]  g_ff, g_in;
   logic [48:0]        prod_ff, prod_in;
   rsp_word_type       out_ff, out_in;
   logic               outv_ff, outv_in;
   req_word_type       req_ff, req_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   slot_type           wr_slot;
   slot_type           rd_slot;
   logic [SLOT_W-1:0]  rd_bits;
   div_cmd_type        dcmd;
   div_rsp_type        drsp;
   logic [CNT_W-1:0]   len;
   logic [PEAK_W-1:0]  ceil_v, m_l, m_r, m_max;
   logic [GAIN_W-1:0]  target;
   logic [48:0]        pl, pr;
   logic [SAMPLE_W-1:0] sl, sr;

   lpl_ram #(.WIDTH(SLOT_W), .DEPTH(LOOKAHEAD_MAX)) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_slot),
      .rd_addr(addr_ff),
      .rd_data(rd_bits)
   );
   assign rd_slot = slot_type'(rd_bits);

   lpl_div u_div (
      .clock(clock),
      .reset(reset),
      .cmd  (dcmd),
      .rsp  (drsp)
   );

   // clamped window length, and ceiling with zero taken as the reset value
   always_comb begin
      if (look_ff < MIN_FRAMES) begin
         len = CNT_W'(MIN_FRAMES);
      end else if (32'(look_ff) > LOOKAHEAD_MAX) begin
         len = CNT_W'(LOOKAHEAD_MAX);
      end else begin
         len = CNT_W'(look_ff);
      end
      ceil_v = (ceil_ff == '0) ? PEAK_W'(CEIL_RESET) : ceil_ff;
   end

   // registers change only between words, never beside an offered word
   assign req_ready = (state_ff == ST_IDLE) && !outv_ff;
   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;
   assign rsp_valid = outv_ff;
   assign rsp_data  = out_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ceil_ff <= CEIL_RESET;
         coef_ff <= COEF_RESET;
         look_ff <= LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CEILING:   ceil_ff <= csr_wdata;
            REG_RELEASE:   coef_ff <= csr_wdata;
            REG_LOOKAHEAD: look_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign m_l   = mag(rd_slot.left);
   assign m_r   = mag(rd_slot.right);
   assign m_max = (m_l > m_r) ? m_l : m_r;
   assign target = (peak_ff > ceil_v) ? drsp.quot : UNITY_GAIN;
   assign sl = mag(old_ff.left);
   assign sr = mag(old_ff.right);
   assign pl = 49'(sl) * 49'(g_ff);
   assign pr = 49'(sr) * 49'(g_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      wpos_in   = wpos_ff;
      fill_in   = fill_ff;
      gain_in   = gain_ff;
      addr_in   = addr_ff;
      cnt_in    = cnt_ff;
      oldest_in = oldest_ff;
      peak_in   = peak_ff;
      later_in  = later_ff;
      first_in  = first_ff;
      rdv_in    = 1'b0;
      rdk0_in   = 1'b0;
      old_in    = old_ff;
      g_in      = g_ff;
      prod_in   = prod_ff;
      out_in    = out_ff;
      outv_in   = outv_ff;
      req_in    = req_ff;
      wr_en     = 1'b0;
      wr_addr   = wpos_ff;
      wr_slot   = '0;
      dcmd      = '0;
      if (outv_ff && rsp_ready) begin
         outv_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(LOOKAHEAD_MAX - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // point the read port at the oldest slot of the coming window
            if (req_valid && req_ready) begin
               req_in   = req_data;
               addr_in  = AW'(wpos_ff + AW'(1) - AW'(len));
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            if (!req_ff.drain) begin
               wr_slot.left      = req_ff.left_in;
               wr_slot.right     = req_ff.right_in;
               wr_slot.real_flag = 1'b1;
            end
            wpos_in = wpos_ff + AW'(1);
            fill_in = (fill_ff < len) ? fill_ff + CNT_W'(1) : fill_ff;
            oldest_in = AW'(wpos_ff + AW'(1) - AW'(len));
            addr_in   = AW'(wpos_ff + AW'(1) - AW'(len));
            cnt_in    = len;
            peak_in   = '0;
            later_in  = 1'b0;
            first_in  = 1'b1;
            if (fill_in < len) begin
               state_in = ST_IDLE;
            end else begin
               rdv_in   = 1'b1;
               rdk0_in  = 1'b1;
               addr_in  = AW'(wpos_ff + AW'(1) - AW'(len)) + AW'(1);
               cnt_in   = len - CNT_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue next read, fold in returned entry
            if (cnt_ff != '0) begin
               rdv_in  = 1'b1;
               addr_in = addr_ff + AW'(1);
               cnt_in  = cnt_ff - CNT_W'(1);
            end
            if (rdv_ff) begin
               if (m_max > peak_ff) begin
                  peak_in = m_max;
               end
               if (rdk0_ff) begin
                  old_in = rd_slot;
                  if (!rd_slot.real_flag) begin
                     state_in = ST_IDLE;
                     rdv_in   = 1'b0;
                  end
               end else if (rd_slot.real_flag) begin
                  later_in = 1'b1;
               end
            end else if (cnt_ff == '0) begin
               // scan complete
               state_in = ST_DIV;
               dcmd.start  = (peak_ff > ceil_v);
               dcmd.ceil_v = ceil_v;
               dcmd.peak   = peak_ff;
               first_in    = (peak_ff > ceil_v);
            end
         end
         ST_DIV: begin
            if (!first_ff || drsp.done) begin
               if (target < gain_ff) begin
                  g_in     = target;
                  state_in = ST_MUL;
               end else begin
                  g_in     = target;
                  prod_in  = 49'(target - gain_ff) * 49'(coef_ff);
                  state_in = ST_REL;
               end
            end
         end
         ST_REL: begin
            g_in     = g_ff - GAIN_W'(prod_ff[48:24]);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            gain_in  = g_ff;
            prod_in  = pl;
            out_in.right_out = old_ff.right[SAMPLE_W-1] ?
               SAMPLE_W'(-pr[47:24]) : SAMPLE_W'(pr[47:24]);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            out_in.left_out = old_ff.left[SAMPLE_W-1] ?
               SAMPLE_W'(-prod_ff[47:24]) : SAMPLE_W'(prod_ff[47:24]);
            out_in.last = !later_ff;
            outv_in     = 1'b1;
            // clear real flag of the emitted slot
            wr_en   = 1'b1;
            wr_addr = oldest_ff;
            wr_slot = old_ff;
            wr_slot.real_flag = 1'b0;
            if (!later_ff) begin
               fill_in = '0;
               gain_in = UNITY_GAIN;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         wpos_ff  <= '0;
         fill_ff  <= '0;
         gain_ff  <= UNITY_GAIN;
         addr_ff  <= '0;
         cnt_ff   <= '0;
         rdv_ff   <= 1'b0;
         rdk0_ff  <= 1'b0;
         outv_ff  <= 1'b0;
         first_ff <= 1'b0;
         later_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wpos_ff  <= wpos_in;
         fill_ff  <= fill_in;
         gain_ff  <= gain_in;
         addr_ff  <= addr_in;
         cnt_ff   <= cnt_in;
         rdv_ff   <= rdv_in;
         rdk0_ff  <= rdk0_in;
         outv_ff  <= outv_in;
         first_ff <= first_in;
         later_ff <= later_in;
      end
      oldest_ff <= oldest_in;
      peak_ff   <= peak_in;
      old_ff    <= old_in;
      g_ff      <= g_in;
      prod_ff   <= prod_in;
      out_ff    <= out_in;
      req_ff    <= req_in;
   end

   // no word accepted while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("word accepted while result pending");

   // a result appears only after the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result without output step");

   // last result restores unity gain
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && rsp_data.last) |-> (gain_ff == UNITY_GAIN))
      else $error("gain not restored after last word");
endmodule

// ===== test/lpl_checker.sv =====
// checker: predicts limited frames from accepted words and compares results
module lpl_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  lpl_pkg::req_word_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  lpl_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [23:0]           csr_wdata,
   output int                    pending,
   output int                    mismatch_count
);
   import lpl_pkg::*;

   localparam int RING_DEPTH = 256;

   // predicted state of the limiter
   logic [SAMPLE_W-1:0] ring_l [RING_DEPTH];
   logic [SAMPLE_W-1:0] ring_r [RING_DEPTH];
   logic                ring_live [RING_DEPTH];
   int                  wr_pos;
   int                  fill;
   longint              gain;
   logic [COEF_W-1:0]   ceil_reg;
   logic [COEF_W-1:0]   coef_reg;
   logic [LEN_W-1:0]    len_reg;
   rsp_word_type        expected_frames [$];

   function automatic longint sample_val(logic [SAMPLE_W-1:0] s);
      return longint'(signed'(s));
   endfunction

   function automatic logic [SAMPLE_W-1:0] apply_gain(logic [SAMPLE_W-1:0] s, longint g);
      longint v;
      longint m;
      v = sample_val(s);
      m = ((v < 0) ? -v : v) * g >>> 24;
      if (v < 0) m = -m;
      return m[SAMPLE_W-1:0];
   endfunction

   // one frame through the limiter; may queue one expected frame
   task automatic limit_frame(req_word_type w);
      int len;
      int oldest;
      int idx;
      longint peak;
      longint a;
      longint b;
      longint ceil_v;
      longint target;
      bit later_live;
      rsp_word_type r;
      len = len_reg;
      if (len < 8) len = 8;
      if (len > RING_DEPTH) len = RING_DEPTH;
      ring_l[wr_pos]    = w.drain ? '0 : w.left_in;
      ring_r[wr_pos]    = w.drain ? '0 : w.right_in;
      ring_live[wr_pos] = !w.drain;
      wr_pos = (wr_pos + 1) % RING_DEPTH;
      if (fill < len) fill++;
      if (fill < len) return;
      oldest = (wr_pos + RING_DEPTH - len) % RING_DEPTH;
      if (!ring_live[oldest]) return;
      peak = 0;
      later_live = 0;
      for (int k = 0; k < len; k++) begin
         idx = (oldest + k) % RING_DEPTH;
         a = sample_val(ring_l[idx]);
         b = sample_val(ring_r[idx]);
         if (a < 0) a = -a;
         if (b < 0) b = -b;
         if (a > peak) peak = a;
         if (b > peak) peak = b;
         if (k > 0 && ring_live[idx]) later_live = 1;
      end
      ceil_v = (ceil_reg == 0) ? 64'd8388608 : longint'(ceil_reg);
      target = (peak > ceil_v) ? (ceil_v << 24) / peak : 64'd16777216;
      if (target < gain) gain = target;
      else gain = target - (((target - gain) * longint'(coef_reg)) >>> 24);
      r.left_out  = apply_gain(ring_l[oldest], gain);
      r.right_out = apply_gain(ring_r[oldest], gain);
      r.last      = !later_live;
      ring_live[oldest] = 0;
      if (!later_live) begin
         fill = 0;
         gain = 64'd16777216;
      end
      expected_frames.push_back(r);
   endtask

   // watch the channels at each edge
   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_l[i] = '0;
            ring_r[i] = '0;
            ring_live[i] = 0;
         end
         wr_pos   = 0;
         fill     = 0;
         gain     = 64'd16777216;
         ceil_reg = CEIL_RESET;
         coef_reg = COEF_RESET;
         len_reg  = LEN_RESET;
         expected_frames.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: left %0d right %0d last %0d",
                           rsp_data.left_out, rsp_data.right_out, rsp_data.last);
            end else begin
               e = expected_frames.pop_front();
               if (e != rsp_data) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                              e.left_out, e.right_out, e.last,
                              rsp_data.left_out, rsp_data.right_out, rsp_data.last);
               end
            end
         end
         if (req_valid && req_ready) limit_frame(req_data);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CEILING:   ceil_reg = csr_wdata;
               REG_RELEASE:   coef_reg = csr_wdata;
               REG_LOOKAHEAD: len_reg  = csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_frames.size();
   end

   initial begin
      pending = 0;
      mismatch_count = 0;
   end

endmodule

// ===== test/tb_top.sv =====
// testbench top: stimulus, idling and verdict for the lookahead peak limiter
module tb_top;
   import lpl_pkg::*;

   localparam longint CYCLE_LIMIT = 6000000;
   localparam int     SETTLE      = 400;
   localparam int     ITEM_TARGET = 1400;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 0;
   rsp_word_type rsp_data;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [1:0]   csr_index = REG_CEILING;
   logic [23:0]  csr_wdata = '0;
   int           pending;
   int           mismatch_count;
   int           send_idle = 0;
   int           recv_idle = 0;
   int           frames_sent = 0;
   longint       cycles = 0;

   lookahead_peak_limiter i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   lpl_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .pending, .mismatch_count
   );

   always #5 clock = ~clock;

   // receiver stalls and run limit
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("lookahead_peak_limiter test failed");
         $finish;
      end
   end

   // idling follows progress through the random part
   task automatic pick_idling();
      if (frames_sent < 550) begin
         send_idle = 25;
         recv_idle = 61;
      end else if (frames_sent < 1100) begin
         send_idle = 61;
         recv_idle = 25;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
   endtask

   task automatic push_word(logic signed [23:0] l, logic signed [23:0] r, logic dr);
      req_word_type w;
      w.left_in = l;
      w.right_in = r;
      w.drain = dr;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= w;
      do @(posedge clock); while (!(req_valid && req_ready));
      frames_sent++;
   endtask

   // wait for every expected word, then for any scan still running
   task automatic settle_down();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // the last word is withdrawn so it is not offered again
   task automatic write_reg(logic [1:0] idx, logic [23:0] v);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [23:0] rand_sample();
      case ($urandom_range(5))
         0: return 24'h800000;
         1: return 24'h7fffff;
         2: return 24'($signed($urandom_range(2000)) - 1000);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] rand_ceiling();
      case ($urandom_range(4))
         0: return 24'd1;
         1: return 24'hffffff;
         2: return 24'd8388608;
         default: return 24'($urandom_range(16777215, 1));
      endcase
   endfunction

   function automatic logic [23:0] rand_coef();
      case ($urandom_range(3))
         0: return 24'd0;
         1: return 24'hffffff;
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      int len;
      int n;
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed: short window, extremes and a full flush
      write_reg(REG_LOOKAHEAD, 24'd8);
      push_word(24'sh7fffff, 24'sh800000, 0);
      push_word(24'sh000000, 24'sh000000, 0);
      push_word(24'sh000001, 24'shffffff, 0);
      push_word(24'sh400000, 24'sh400001, 0);
      push_word(24'sh123456, 24'shedcba9, 1);
      repeat (8) push_word(24'sh0, 24'sh0, 1);
      settle_down();
      // zero ceiling, no release smoothing, window below the minimum
      write_reg(REG_CEILING, 24'd0);
      write_reg(REG_RELEASE, 24'd0);
      write_reg(REG_LOOKAHEAD, 24'd0);
      push_word(24'sh7fffff, 24'sh000010, 0);
      push_word(24'sh100000, 24'sh800000, 0);
      push_word(24'sh000100, 24'sh000200, 0);
      repeat (5) push_word(24'sh0, 24'sh0, 1);
      // window grows mid-block
      settle_down();
      write_reg(REG_LOOKAHEAD, 24'd12);
      repeat (4) push_word(24'sh0, 24'sh0, 1);
      settle_down();
      // window shrinks mid-block, then flush
      push_word(24'sh7fffff, 24'sh7fffff, 0);
      write_reg(REG_LOOKAHEAD, 24'd8);
      repeat (8) push_word(24'sh0, 24'sh0, 1);
      settle_down();
      len = 8;

      // random blocks with occasional register changes
      while (frames_sent < ITEM_TARGET) begin
         pick_idling();
         if ($urandom_range(3) == 0) begin
            settle_down();
            write_reg(REG_CEILING, rand_ceiling());
            write_reg(REG_RELEASE, rand_coef());
            case ($urandom_range(19))
               0: len = 256;
               1: len = 511;
               2: len = 300;
               3: len = $urandom_range(7);
               default: len = $urandom_range(24, 8);
            endcase
            write_reg(REG_LOOKAHEAD, 24'(len));
            if (len < 8) len = 8;
            if (len > 256) len = 256;
         end else if (frames_sent == 0) begin
            len = 8;
         end
         n = $urandom_range(40, 1);
         for (int i = 0; i < n; i++)
            push_word(rand_sample(), rand_sample(), ($urandom_range(9) == 0));
         // mostly a full flush, sometimes partial or none
         case ($urandom_range(4))
            0: n = $urandom_range(len);
            1: n = 0;
            default: n = len;
         endcase
         for (int i = 0; i < n; i++)
            push_word(24'($urandom), 24'($urandom), 1);
      end
      // final flush of whatever remains
      repeat (256) push_word(24'sh0, 24'sh0, 1);
      settle_down();

      if (mismatch_count == 0 && pending == 0)
         $display("lookahead_peak_limiter test passed");
      else
         $display("lookahead_peak_limiter test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/lpl_pkg.sv
sv/lpl_ram.sv
sv/lpl_div.sv
sv/lookahead_peak_limiter.sv
test/lpl_checker.sv
test/tb_top.sv
